@@ hdl/hsvld_pkg.sv @@
package hsvld_pkg;

  // fixed field and format widths
  localparam int FACTOR_W = 14;
  localparam int FRAC_W   = 16;
  localparam int SAT_W    = 17;
  localparam int HUE_W    = 19;
  localparam int SEC_W    = 3;

  localparam logic [FACTOR_W-1:0] PERCENT = 14'd100;
  localparam logic [SAT_W-1:0]    ONE_Q16 = 17'h10000;

  // hue sector base for the channel that holds the maximum
  localparam logic [SEC_W-1:0] HUE_BASE_RED      = 3'd0;
  localparam logic [SEC_W-1:0] HUE_BASE_GREEN    = 3'd2;
  localparam logic [SEC_W-1:0] HUE_BASE_BLUE     = 3'd4;
  localparam logic [SEC_W-1:0] HUE_BASE_RED_WRAP = 3'd6;

  typedef enum logic [SEC_W-1:0] {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } sector_t;

  // per-word control flags that travel down the pipe
  typedef struct packed {
    logic lighten;
    logic pass;
    logic gray;
  } ctl_t;

  // floor(10000 / f) for f below 100, entry 0 unused
  localparam logic [FACTOR_W-1:0] RECIP [100] = '{
    0, 10000, 5000, 3333, 2500, 2000, 1666, 1428, 1250, 1111,
    1000, 909, 833, 769, 714, 666, 625, 588, 555, 526,
    500, 476, 454, 434, 416, 400, 384, 370, 357, 344,
    333, 322, 312, 303, 294, 285, 277, 270, 263, 256,
    250, 243, 238, 232, 227, 222, 217, 212, 208, 204,
    200, 196, 192, 188, 185, 181, 178, 175, 172, 169,
    166, 163, 161, 158, 156, 153, 151, 149, 147, 144,
    142, 140, 138, 136, 135, 133, 131, 129, 128, 126,
    125, 123, 121, 120, 119, 117, 116, 114, 113, 112,
    111, 109, 108, 107, 106, 105, 104, 103, 102, 101
  };

endpackage

@@ hdl/hsvld_div.sv @@
module hsvld_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int QUO_W  = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  localparam int CMP_W = NUM_W + DEN_W + QUO_W;

  logic              vld    [QUO_W];
  logic [NUM_W-1:0]  rem_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  // one restoring step per stage, msb of the quotient first
  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic              vs;
    logic [NUM_W-1:0]  rs;
    logic [DEN_W-1:0]  ds;
    logic [QUO_W-1:0]  qs;
    logic [SIDE_W-1:0] ss;
    logic [CMP_W-1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign vs = in_valid;
      assign rs = num;
      assign ds = den;
      assign qs = '0;
      assign ss = side_in;
    end else begin : g_next
      assign vs = vld[k-1];
      assign rs = rem_q[k-1];
      assign ds = den_q[k-1];
      assign qs = quo_q[k-1];
      assign ss = side_q[k-1];
    end

    assign trial = CMP_W'(ds) << (QUO_W - 1 - k);
    assign take  = CMP_W'(rs) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vs;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= take ? rs - NUM_W'(trial) : rs;
        quo_q[k]  <= (qs << 1) | QUO_W'(take);
        den_q[k]  <= ds;
        side_q[k] <= ss;
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quo       = quo_q[QUO_W-1];
  assign side_out  = side_q[QUO_W-1];

endmodule

@@ hdl/hsvld_front.sv @@
module hsvld_front #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic                                   operation,
  input  logic [hsvld_pkg::FACTOR_W-1:0]         factor,
  input  logic [15:0]                            red_in,
  input  logic [15:0]                            green_in,
  input  logic [15:0]                            blue_in,
  input  logic [15:0]                            alpha_in,
  output logic                                   out_valid,
  output hsvld_pkg::ctl_t                        ctl,
  output logic [COMPONENT_WIDTH-1:0]             red,
  output logic [COMPONENT_WIDTH-1:0]             green,
  output logic [COMPONENT_WIDTH-1:0]             blue,
  output logic [15:0]                            alpha,
  output logic [COMPONENT_WIDTH-1:0]             max_c,
  output logic [COMPONENT_WIDTH-1:0]             delta,
  output logic [COMPONENT_WIDTH-1:0]             diff,
  output logic                                   diff_neg,
  output logic [hsvld_pkg::SEC_W-1:0]            hue_base,
  output logic [COMPONENT_WIDTH+hsvld_pkg::FACTOR_W-1:0] prod,
  output logic [hsvld_pkg::FACTOR_W-1:0]         den
);

  import hsvld_pkg::*;

  localparam int W   = COMPONENT_WIDTH;
  localparam int P_W = W + FACTOR_W;

  // factor fixup: small factors swap the operation and take the reciprocal
  logic                low_f;
  logic [6:0]          idx;
  logic [FACTOR_W-1:0] fa;

  assign low_f = factor < PERCENT;
  assign idx   = low_f ? factor[6:0] : '0;
  assign fa    = low_f ? RECIP[idx] : factor;

  logic                v1;
  logic                light1;
  logic                pass1;
  logic [FACTOR_W-1:0] fa1;
  logic [W-1:0]        r1;
  logic [W-1:0]        g1;
  logic [W-1:0]        b1;
  logic [15:0]         a1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      light1 <= ~operation ^ low_f;
      pass1  <= factor == '0;
      fa1    <= fa;
      r1     <= red_in[W-1:0];
      g1     <= green_in[W-1:0];
      b1     <= blue_in[W-1:0];
      a1     <= alpha_in;
    end
  end

  // max, min and hue numerator for the sector of the maximum
  logic [W-1:0]        mx;
  logic [W-1:0]        mn;
  logic [W-1:0]        hp;
  logic [W-1:0]        hq;
  logic                neg;
  logic [SEC_W-1:0]    base;
  logic [FACTOR_W-1:0] mul;
  logic [FACTOR_W-1:0] dv;

  always_comb begin
    mx = (r1 > g1) ? r1 : g1;
    if (b1 > mx) begin
      mx = b1;
    end
    mn = (r1 < g1) ? r1 : g1;
    if (b1 < mn) begin
      mn = b1;
    end
    priority if (r1 == mx) begin
      hp = g1;
      hq = b1;
    end else if (g1 == mx) begin
      hp = b1;
      hq = r1;
    end else begin
      hp = r1;
      hq = g1;
    end
    neg = hp < hq;
    priority if (r1 == mx) begin
      base = neg ? HUE_BASE_RED_WRAP : HUE_BASE_RED;
    end else if (g1 == mx) begin
      base = HUE_BASE_GREEN;
    end else begin
      base = HUE_BASE_BLUE;
    end
    mul = light1 ? fa1 : PERCENT;
    dv  = light1 ? PERCENT : fa1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.lighten <= light1;
      ctl.pass    <= pass1;
      ctl.gray    <= mx == mn;
      red         <= r1;
      green       <= g1;
      blue        <= b1;
      alpha       <= a1;
      max_c       <= mx;
      delta       <= mx - mn;
      diff        <= neg ? hq - hp : hp - hq;
      diff_neg    <= neg;
      hue_base    <= base;
      prod        <= P_W'(mx) * P_W'(mul);
      den         <= dv;
    end
  end

endmodule

@@ hdl/hsvld_back.sv @@
module hsvld_back #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [COMPONENT_WIDTH+23:0]       val,
  input  hsvld_pkg::ctl_t                   ctl,
  input  logic [hsvld_pkg::SAT_W-1:0]       sat,
  input  logic [hsvld_pkg::HUE_W-1:0]       hue,
  input  logic [COMPONENT_WIDTH-1:0]        red,
  input  logic [COMPONENT_WIDTH-1:0]        green,
  input  logic [COMPONENT_WIDTH-1:0]        blue,
  input  logic [15:0]                       alpha,
  output logic                              out_valid,
  output logic [15:0]                       red_out,
  output logic [15:0]                       green_out,
  output logic [15:0]                       blue_out,
  output logic [15:0]                       alpha_out
);

  import hsvld_pkg::*;

  localparam int W     = COMPONENT_WIDTH;
  localparam int VQ_W  = W + 24;
  localparam int VF_W  = W + FRAC_W;
  localparam int SF_W  = W + SAT_W;
  localparam int CQ_W  = W + 33;
  localparam int PH_W  = W + 26;
  localparam int PL_W  = 41;
  localparam int XP_W  = W + 50;
  localparam int MF_W  = W + 32;

  localparam logic [W-1:0]    FS  = '1;
  localparam logic [VQ_W-1:0] FSQ = {8'd0, {W{1'b1}}, {FRAC_W{1'b0}}};

  // value clip and excess against saturation times full scale
  logic            over;
  logic            e1_v;
  logic            e1_over;
  logic [VQ_W-1:0] e1_e;
  logic [SF_W-1:0] e1_sfs;
  logic [VF_W-1:0] e1_vc;
  logic [SAT_W-1:0] e1_s;
  logic [HUE_W-1:0] e1_h;
  ctl_t            e1_ctl;
  logic [W-1:0]    e1_r;
  logic [W-1:0]    e1_g;
  logic [W-1:0]    e1_b;
  logic [15:0]     e1_a;

  assign over = ctl.lighten && (val > FSQ);

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
    end else if (en) begin
      e1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_over <= over;
      e1_e    <= val - FSQ;
      e1_sfs  <= SF_W'(sat) * SF_W'(FS);
      e1_vc   <= over ? FSQ[VF_W-1:0] : val[VF_W-1:0];
      e1_s    <= sat;
      e1_h    <= hue;
      e1_ctl  <= ctl;
      e1_r    <= red;
      e1_g    <= green;
      e1_b    <= blue;
      e1_a    <= alpha;
    end
  end

  // excess divided by full scale: with e = q * 2^W + r, e / fs = q + (q + r) / fs,
  // so the high part is folded onto the low part three times
  logic             flag;
  logic [VF_W-1:0]  ex0;
  logic [VF_W-1:0]  fold1;
  logic             x1_v;
  logic [VF_W-1:0]  x1_quo;
  logic [VF_W-1:0]  x1_rest;
  logic             x1_over;
  logic             x1_flag;
  logic [SAT_W-1:0] x1_s;
  logic [HUE_W-1:0] x1_h;
  logic [VF_W-1:0]  x1_vc;
  ctl_t             x1_ctl;
  logic [W-1:0]     x1_r;
  logic [W-1:0]     x1_g;
  logic [W-1:0]     x1_b;
  logic [15:0]      x1_a;

  assign flag  = e1_e < VQ_W'(e1_sfs);
  assign ex0   = e1_e[VF_W-1:0];
  assign fold1 = VF_W'(ex0[VF_W-1:W]) + VF_W'(ex0[W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_v <= 1'b0;
    end else if (en) begin
      x1_v <= e1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_quo  <= VF_W'(ex0[VF_W-1:W]);
      x1_rest <= fold1;
      x1_over <= e1_over;
      x1_flag <= flag;
      x1_s    <= e1_s;
      x1_h    <= e1_h;
      x1_vc   <= e1_vc;
      x1_ctl  <= e1_ctl;
      x1_r    <= e1_r;
      x1_g    <= e1_g;
      x1_b    <= e1_b;
      x1_a    <= e1_a;
    end
  end

  // second and third fold, remainder is then below twice full scale
  logic [VF_W-1:0]  fold2;
  logic [VF_W-1:0]  fold3;
  logic             x2_v;
  logic [VF_W-1:0]  x2_quo;
  logic [VF_W-1:0]  x2_rest;
  logic             x2_over;
  logic             x2_flag;
  logic [SAT_W-1:0] x2_s;
  logic [HUE_W-1:0] x2_h;
  logic [VF_W-1:0]  x2_vc;
  ctl_t             x2_ctl;
  logic [W-1:0]     x2_r;
  logic [W-1:0]     x2_g;
  logic [W-1:0]     x2_b;
  logic [15:0]      x2_a;

  assign fold2 = VF_W'(x1_rest[VF_W-1:W]) + VF_W'(x1_rest[W-1:0]);
  assign fold3 = VF_W'(fold2[VF_W-1:W]) + VF_W'(fold2[W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      x2_v <= 1'b0;
    end else if (en) begin
      x2_v <= x1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_quo  <= x1_quo + VF_W'(x1_rest[VF_W-1:W]) + VF_W'(fold2[VF_W-1:W]);
      x2_rest <= fold3;
      x2_over <= x1_over;
      x2_flag <= x1_flag;
      x2_s    <= x1_s;
      x2_h    <= x1_h;
      x2_vc   <= x1_vc;
      x2_ctl  <= x1_ctl;
      x2_r    <= x1_r;
      x2_g    <= x1_g;
      x2_b    <= x1_b;
      x2_a    <= x1_a;
    end
  end

  // saturation after the excess is taken off
  logic [VF_W-1:0]  ex_full;
  logic [SAT_W-1:0] ex_q;
  logic             c1_v;
  logic [SAT_W-1:0] c1_s;
  logic [HUE_W-1:0] c1_h;
  logic [VF_W-1:0]  c1_vc;
  ctl_t             c1_ctl;
  logic [W-1:0]     c1_r;
  logic [W-1:0]     c1_g;
  logic [W-1:0]     c1_b;
  logic [15:0]      c1_a;

  assign ex_full = x2_quo + VF_W'(x2_rest >= VF_W'(FS));
  assign ex_q    = ex_full[SAT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
    end else if (en) begin
      c1_v <= x2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_s   <= !x2_over ? x2_s : (x2_flag ? x2_s - ex_q : '0);
      c1_h   <= x2_h;
      c1_vc  <= x2_vc;
      c1_ctl <= x2_ctl;
      c1_r   <= x2_r;
      c1_g   <= x2_g;
      c1_b   <= x2_b;
      c1_a   <= x2_a;
    end
  end

  // chroma product and sector weight
  logic [SAT_W-1:0] t;
  logic [SAT_W-1:0] d;
  logic             c2_v;
  logic [CQ_W-1:0]  c2_cq;
  logic [SAT_W-1:0] c2_w;
  sector_t          c2_sec;
  logic [VF_W-1:0]  c2_vc;
  ctl_t             c2_ctl;
  logic [W-1:0]     c2_r;
  logic [W-1:0]     c2_g;
  logic [W-1:0]     c2_b;
  logic [15:0]      c2_a;

  assign t = c1_h[SAT_W-1:0];
  assign d = (t >= ONE_Q16) ? t - ONE_Q16 : ONE_Q16 - t;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_v <= 1'b0;
    end else if (en) begin
      c2_v <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_cq  <= CQ_W'(c1_vc) * CQ_W'(c1_s);
      c2_w   <= ONE_Q16 - d;
      c2_sec <= sector_t'(c1_h[HUE_W-1:FRAC_W]);
      c2_vc  <= c1_vc;
      c2_ctl <= c1_ctl;
      c2_r   <= c1_r;
      c2_g   <= c1_g;
      c2_b   <= c1_b;
      c2_a   <= c1_a;
    end
  end

  // weighted chroma in two partial products, offset term
  logic [MF_W-1:0] mfull;
  logic            c3_v;
  logic [PH_W-1:0] c3_phi;
  logic [PL_W-1:0] c3_plo;
  logic [W-1:0]    c3_c;
  logic [W-1:0]    c3_m;
  logic [W-1:0]    c3_gv;
  sector_t         c3_sec;
  ctl_t            c3_ctl;
  logic [W-1:0]    c3_r;
  logic [W-1:0]    c3_g;
  logic [W-1:0]    c3_b;
  logic [15:0]     c3_a;

  assign mfull = {c2_vc, {FRAC_W{1'b0}}} - MF_W'(c2_cq);

  always_ff @(posedge clk) begin
    if (rst) begin
      c3_v <= 1'b0;
    end else if (en) begin
      c3_v <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_phi <= PH_W'(c2_cq[CQ_W-1:24]) * PH_W'(c2_w);
      c3_plo <= PL_W'(c2_cq[23:0]) * PL_W'(c2_w);
      c3_c   <= c2_cq[W+31:32];
      c3_m   <= mfull[W+31:32];
      c3_gv  <= c2_vc[VF_W-1:FRAC_W];
      c3_sec <= c2_sec;
      c3_ctl <= c2_ctl;
      c3_r   <= c2_r;
      c3_g   <= c2_g;
      c3_b   <= c2_b;
      c3_a   <= c2_a;
    end
  end

  // place chroma by sector and add the offset
  logic [XP_W-1:0] xs;
  logic [W-1:0]    x;
  logic [W-1:0]    rc;
  logic [W-1:0]    gc;
  logic [W-1:0]    bc;
  logic [W-1:0]    rs;
  logic [W-1:0]    gs;
  logic [W-1:0]    bs;

  assign xs = (XP_W'(c3_phi) << 24) + XP_W'(c3_plo);
  assign x  = xs[W+47:48];

  always_comb begin
    unique case (c3_sec)
      SEC_RED_YELLOW: begin
        rc = c3_c;
        gc = x;
        bc = '0;
      end
      SEC_YELLOW_GREEN: begin
        rc = x;
        gc = c3_c;
        bc = '0;
      end
      SEC_GREEN_CYAN: begin
        rc = '0;
        gc = c3_c;
        bc = x;
      end
      SEC_CYAN_BLUE: begin
        rc = '0;
        gc = x;
        bc = c3_c;
      end
      SEC_BLUE_MAGENTA: begin
        rc = x;
        gc = '0;
        bc = c3_c;
      end
      default: begin
        rc = c3_c;
        gc = '0;
        bc = x;
      end
    endcase
    priority if (c3_ctl.pass) begin
      rs = c3_r;
      gs = c3_g;
      bs = c3_b;
    end else if (c3_ctl.gray) begin
      rs = c3_gv;
      gs = c3_gv;
      bs = c3_gv;
    end else begin
      rs = rc + c3_m;
      gs = gc + c3_m;
      bs = bc + c3_m;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_out   <= 16'(rs);
      green_out <= 16'(gs);
      blue_out  <= 16'(bs);
      alpha_out <= c3_a;
    end
  end

endmodule

@@ hdl/hsv_lighten_darken.sv @@
// channel | handshake            | fields
// --------+----------------------+---------------------------------------------
// in      | in_valid / in_stall  | operation, factor, red_in, green_in,
//         |                      | blue_in, alpha_in
// out     | out_valid / out_stall| red_out, green_out, blue_out, alpha_out
//
// one word per clock while the output is not stalled
// the pipe is a chain of bit-per-stage dividers: saturation and hue
// (17 stages), scaled value (COMPONENT_WIDTH + 24), plus front (2) and back end (7)
// rst is synchronous and clears only the valid bits of every stage
// a stalled output word freezes the whole pipe and raises in_stall
module hsv_lighten_darken #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  input  logic [hsvld_pkg::FACTOR_W-1:0] factor,
  input  logic [15:0]                    red_in,
  input  logic [15:0]                    green_in,
  input  logic [15:0]                    blue_in,
  input  logic [15:0]                    alpha_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    red_out,
  output logic [15:0]                    green_out,
  output logic [15:0]                    blue_out,
  output logic [15:0]                    alpha_out
);

  import hsvld_pkg::*;

  localparam int W    = COMPONENT_WIDTH;
  localparam int P_W  = W + FACTOR_W;
  localparam int VN_W = P_W + FRAC_W;
  localparam int VQ_W = W + 24;
  localparam int SD_W = $bits(ctl_t) + 4 * W + 44;
  localparam int HD_W = SEC_W + 1;
  localparam int VS_W = $bits(ctl_t) + SAT_W + HUE_W + 3 * W + 16;

  // global advance: hold everything while the output word is stalled
  logic en;

  assign in_stall = out_valid & out_stall;
  assign en       = ~in_stall;

  // fixup, max/min and value product
  logic                f_valid;
  ctl_t                f_ctl;
  logic [W-1:0]        f_red;
  logic [W-1:0]        f_green;
  logic [W-1:0]        f_blue;
  logic [15:0]         f_alpha;
  logic [W-1:0]        f_max;
  logic [W-1:0]        f_delta;
  logic [W-1:0]        f_diff;
  logic                f_neg;
  logic [SEC_W-1:0]    f_base;
  logic [P_W-1:0]      f_prod;
  logic [FACTOR_W-1:0] f_den;

  hsvld_front #(
    .COMPONENT_WIDTH (W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .operation (operation),
    .factor    (factor),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .out_valid (f_valid),
    .ctl       (f_ctl),
    .red       (f_red),
    .green     (f_green),
    .blue      (f_blue),
    .alpha     (f_alpha),
    .max_c     (f_max),
    .delta     (f_delta),
    .diff      (f_diff),
    .diff_neg  (f_neg),
    .hue_base  (f_base),
    .prod      (f_prod),
    .den       (f_den)
  );

  // saturation and hue fraction dividers run side by side
  logic                sd_valid;
  logic [SAT_W-1:0]    sat_q;
  logic [SD_W-1:0]     sd_side;
  logic                hd_valid;
  logic [SAT_W-1:0]    hue_q;
  logic [HD_W-1:0]     hd_side;

  hsvld_div #(
    .NUM_W  (W + FRAC_W),
    .DEN_W  (W),
    .QUO_W  (SAT_W),
    .SIDE_W (SD_W)
  ) u_sat_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num       ({f_delta, {FRAC_W{1'b0}}}),
    .den       (f_max),
    .side_in   ({f_ctl, f_red, f_green, f_blue, f_alpha, f_prod, f_den}),
    .out_valid (sd_valid),
    .quo       (sat_q),
    .side_out  (sd_side)
  );

  hsvld_div #(
    .NUM_W  (W + FRAC_W),
    .DEN_W  (W),
    .QUO_W  (SAT_W),
    .SIDE_W (HD_W)
  ) u_hue_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num       ({f_diff, {FRAC_W{1'b0}}}),
    .den       (f_delta),
    .side_in   ({f_neg, f_base}),
    .out_valid (hd_valid),
    .quo       (hue_q),
    .side_out  (hd_side)
  );

  ctl_t                d_ctl;
  logic [W-1:0]        d_red;
  logic [W-1:0]        d_green;
  logic [W-1:0]        d_blue;
  logic [15:0]         d_alpha;
  logic [P_W-1:0]      d_prod;
  logic [FACTOR_W-1:0] d_den;
  logic                d_neg;
  logic [SEC_W-1:0]    d_base;
  logic [HUE_W-1:0]    hue;

  assign {d_ctl, d_red, d_green, d_blue, d_alpha, d_prod, d_den} = sd_side;
  assign {d_neg, d_base} = hd_side;

  // hue as sector base plus or minus the fraction
  assign hue = d_neg ? {d_base, {FRAC_W{1'b0}}} - HUE_W'(hue_q)
                     : {d_base, {FRAC_W{1'b0}}} + HUE_W'(hue_q);

  // scaled value divider
  logic             vd_valid;
  logic [VQ_W-1:0]  val_q;
  logic [VS_W-1:0]  vd_side;
  ctl_t             v_ctl;
  logic [SAT_W-1:0] v_sat;
  logic [HUE_W-1:0] v_hue;
  logic [W-1:0]     v_red;
  logic [W-1:0]     v_green;
  logic [W-1:0]     v_blue;
  logic [15:0]      v_alpha;

  hsvld_div #(
    .NUM_W  (VN_W),
    .DEN_W  (FACTOR_W),
    .QUO_W  (VQ_W),
    .SIDE_W (VS_W)
  ) u_val_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sd_valid & hd_valid),
    .num       ({d_prod, {FRAC_W{1'b0}}}),
    .den       (d_den),
    .side_in   ({d_ctl, sat_q, hue, d_red, d_green, d_blue, d_alpha}),
    .out_valid (vd_valid),
    .quo       (val_q),
    .side_out  (vd_side)
  );

  assign {v_ctl, v_sat, v_hue, v_red, v_green, v_blue, v_alpha} = vd_side;

  // clip, saturation fixup and conversion back to rgb
  hsvld_back #(
    .COMPONENT_WIDTH (W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vd_valid),
    .val       (val_q),
    .ctl       (v_ctl),
    .sat       (v_sat),
    .hue       (v_hue),
    .red       (v_red),
    .green     (v_green),
    .blue      (v_blue),
    .alpha     (v_alpha),
    .out_valid (out_valid),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out)
  );

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hsvld_pkg::*;

  localparam int CW = 16;
  localparam int LATENCY = CW + 50;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } pixel_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic operation;
  logic [FACTOR_W-1:0] factor;
  logic [15:0] red_in, green_in, blue_in, alpha_in;
  logic out_valid;
  logic out_stall;
  logic [15:0] red_out, green_out, blue_out, alpha_out;

  pixel_t expected_pixels[$];
  int errors;
  int burst_left;

  hsv_lighten_darken #(.COMPONENT_WIDTH(CW)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // compute the adjusted pixel for one input word
  function automatic pixel_t adjust_pixel(logic op, logic [FACTOR_W-1:0] fin,
                                          logic [15:0] r16, logic [15:0] g16,
                                          logic [15:0] b16, logic [15:0] a16);
    logic [63:0] fs, fsq, f, r, g, b, mx, mn, delta, v, s, h, ex;
    logic [63:0] t, d, w, cq, c, x, m, ro, go, bo;
    logic [127:0] cw;
    logic lighten;
    pixel_t p;
    fs = (64'd1 << CW) - 64'd1;
    fsq = fs << 16;
    lighten = (op == 1'b0);
    f = 64'(fin);
    r = 64'(r16) & fs;
    g = 64'(g16) & fs;
    b = 64'(b16) & fs;
    p.alpha = a16;
    s = 0;
    h = 0;
    if (f == 0) begin
      p.red = r[15:0]; p.green = g[15:0]; p.blue = b[15:0];
      return p;
    end
    if (f < 100) begin
      lighten = !lighten;
      f = 10000 / f;
    end
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    delta = mx - mn;
    v = mx << 16;
    if (delta != 0) begin
      s = (delta << 16) / mx;
      if (r == mx) begin
        if (g >= b) h = ((g - b) << 16) / delta;
        else h = 6 * 65536 - (((b - g) << 16) / delta);
      end else if (g == mx) begin
        if (b >= r) h = 2 * 65536 + (((b - r) << 16) / delta);
        else h = 2 * 65536 - (((r - b) << 16) / delta);
      end else begin
        if (r >= g) h = 4 * 65536 + (((r - g) << 16) / delta);
        else h = 4 * 65536 - (((g - r) << 16) / delta);
      end
    end
    if (lighten) begin
      v = (v * f) / 100;
      if (v > fsq) begin
        ex = (v - fsq) / fs;
        s = (s > ex) ? s - ex : 0;
        v = fsq;
      end
    end else begin
      v = (v * 100) / f;
    end
    if (delta == 0) begin
      ro = v >> 16; go = ro; bo = ro;
    end else begin
      t = h & 64'h1FFFF;
      d = (t >= 65536) ? t - 65536 : 65536 - t;
      w = 65536 - d;
      cq = v * s;
      c = cq >> 32;
      cw = {64'd0, cq} * {64'd0, w};
      x = 64'(cw >> 48);
      m = ((v << 16) - cq) >> 32;
      case (h >> 16)
        64'd0: begin ro = c; go = x; bo = 0; end
        64'd1: begin ro = x; go = c; bo = 0; end
        64'd2: begin ro = 0; go = c; bo = x; end
        64'd3: begin ro = 0; go = x; bo = c; end
        64'd4: begin ro = x; go = 0; bo = c; end
        default: begin ro = c; go = 0; bo = x; end
      endcase
      ro += m; go += m; bo += m;
    end
    p.red = ro[15:0];
    p.green = go[15:0];
    p.blue = bo[15:0];
    return p;
  endfunction

  // send one word at the next falling edge, with bursty gaps
  task automatic send_word(logic op, logic [FACTOR_W-1:0] f, logic [15:0] r,
                           logic [15:0] g, logic [15:0] b, logic [15:0] a);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    operation <= op;
    factor <= f;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    alpha_in <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pixels.push_back(adjust_pixel(op, f, r, g, b, a));
  endtask

  // drop valid after the last word of a sequence
  task automatic bus_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // random factor biased toward the interesting ranges
  function automatic logic [FACTOR_W-1:0] pick_factor();
    case ($urandom_range(0, 5))
      0: return FACTOR_W'($urandom_range(0, 99));
      1: return FACTOR_W'($urandom_range(100, 300));
      2: return FACTOR_W'($urandom_range(0, 10000));
      3: return FACTOR_W'($urandom_range(0, 16383));
      default: return FACTOR_W'($urandom_range(1, 1000));
    endcase
  endfunction

  task automatic test_directed();
    send_word(1'b0, 14'd0, 16'h1234, 16'hABCD, 16'hFFFF, 16'h5A5A);
    send_word(1'b1, 14'd0, 16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF);
    send_word(1'b0, 14'd100, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    send_word(1'b1, 14'd100, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_word(1'b0, 14'd150, 16'h8000, 16'h8000, 16'h8000, 16'h0001);
    send_word(1'b1, 14'd200, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000);
    send_word(1'b0, 14'd10000, 16'h4000, 16'h2000, 16'h1000, 16'h0);
    send_word(1'b1, 14'd10000, 16'hFFFF, 16'h0001, 16'h8000, 16'h0);
    send_word(1'b0, 14'd16383, 16'h0100, 16'h0200, 16'h0300, 16'h0);
    send_word(1'b1, 14'd16383, 16'h0000, 16'h0000, 16'h0000, 16'h0);
    send_word(1'b0, 14'd1, 16'hC000, 16'h4000, 16'h8000, 16'h1);
    send_word(1'b1, 14'd1, 16'h1000, 16'h2000, 16'h3000, 16'h2);
    send_word(1'b0, 14'd99, 16'hFFFF, 16'hFF00, 16'h0000, 16'h3);
    send_word(1'b1, 14'd50, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h4);
    send_word(1'b0, 14'd300, 16'h1000, 16'h0000, 16'h2000, 16'h5);
    send_word(1'b0, 14'd120, 16'h2000, 16'h0000, 16'h1000, 16'h6);
    send_word(1'b1, 14'd333, 16'h0000, 16'h0000, 16'h0001, 16'h7);
    send_word(1'b0, 14'd101, 16'h0001, 16'h0000, 16'h0000, 16'h8);
    bus_idle();
  endtask

  task automatic test_random_pixels(int n);
    logic [15:0] base;
    for (int i = 0; i < n; i++) begin
      base = 16'($urandom);
      if ($urandom_range(0, 7) == 0)
        send_word(1'($urandom), pick_factor(), base, base, base, 16'($urandom));
      else
        send_word(1'($urandom), pick_factor(), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    end
    bus_idle();
  endtask

  // let the pipe drain fully before going on
  task automatic test_drain_pause();
    while (expected_pixels.size() != 0) @(negedge clk);
    test_random_pixels(20);
  endtask

  // result checking for each accepted output word
  always @(posedge clk) begin
    pixel_t exp_px;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected word: red %h green %h blue %h alpha %h",
               red_out, green_out, blue_out, alpha_out);
        errors++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (red_out !== exp_px.red) begin
          $error("red_out expected %h actual %h", exp_px.red, red_out); errors++;
        end
        if (green_out !== exp_px.green) begin
          $error("green_out expected %h actual %h", exp_px.green, green_out); errors++;
        end
        if (blue_out !== exp_px.blue) begin
          $error("blue_out expected %h actual %h", exp_px.blue, blue_out); errors++;
        end
        if (alpha_out !== exp_px.alpha) begin
          $error("alpha_out expected %h actual %h", exp_px.alpha, alpha_out); errors++;
        end
      end
    end
  end

  // receiver stalls in phases: none, light, heavy
  always @(negedge clk) begin
    case (($time / 20000) % 3)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin
    #20ms;
    $display("** hsv_lighten_darken: FAILED **");
    $finish;
  end

  initial begin
    errors = 0;
    burst_left = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = 1'b0;
    factor = '0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    alpha_in = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_pixels(250);
    test_drain_pause();
    test_random_pixels(270);
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
    if (errors == 0 && expected_pixels.size() == 0)
      $display("** hsv_lighten_darken: PASSED **");
    else
      $display("** hsv_lighten_darken: FAILED **");
    $finish;
  end
endmodule
